// ----- sv/tafl_pkg.sv -----
// Package with the shared types, codes and constants of the timed alpha fade block.
package tafl_pkg;

  // Event kinds carried by an input beat.
  typedef enum logic [1:0] {
    KIND_SET_TARGET = 2'd0,
    KIND_AUTHORIZE  = 2'd1,
    KIND_REVOKE     = 2'd2,
    KIND_ADVANCE    = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FADE_DURATION      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STALE_BOUND        = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERACTION_CUTOFF = 2'd2;

  // Register reset values.
  localparam logic [15:0] FADE_DURATION_RESET      = 16'd250;
  localparam logic [31:0] STALE_BOUND_RESET        = 32'd2000;
  localparam logic [7:0]  INTERACTION_CUTOFF_RESET = 8'd128;

  // Serial multiply and divide lengths of the fade unit.
  localparam int MUL_STEPS = 8;
  localparam int DIV_STEPS = 24;
  localparam int CNT_W     = 5;

  // Top level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FADE,
    ST_EMIT
  } top_state_t;

  // Fade unit states.
  typedef enum logic [1:0] {
    FU_IDLE,
    FU_MUL,
    FU_DIV,
    FU_FIN
  } fade_state_t;

  // Request to the fade unit.
  typedef struct packed {
    logic        go;
    logic [7:0]  from_level;
    logic [7:0]  to_level;
    logic [31:0] elapsed;
  } fade_req_t;

  // Answer of the fade unit.
  typedef struct packed {
    logic       done;
    logic [7:0] level;
  } fade_rsp_t;

endpackage

// ----- sv/tafl_event_if.sv -----
// Interface of the input event channel.
interface tafl_event_if;
  logic               valid;
  logic               ready;
  tafl_pkg::kind_t    kind;
  logic [7:0]         target_level;
  logic [31:0]        time_stamp;

  modport source (output valid, kind, target_level, time_stamp, input ready);
  modport sink   (input valid, kind, target_level, time_stamp, output ready);
endinterface

// ----- sv/tafl_result_if.sv -----
// Interface of the result channel.
interface tafl_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic       changed;
  logic       interactive;

  modport source (output valid, level, changed, interactive, input ready);
  modport sink   (input valid, level, changed, interactive, output ready);
endinterface

// ----- sv/tafl_cfg_if.sv -----
// Interface of the configuration write channel.
interface tafl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tafl_pkg::CFG_INDEX_W-1:0] index;
  logic [31:0]                      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/tafl_fade_unit.sv -----
// Fade unit: bit-serial multiply and restoring divide for the rounded linear fade.
module tafl_fade_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         duration,
  input  tafl_pkg::fade_req_t req,
  output tafl_pkg::fade_rsp_t rsp
);
  import tafl_pkg::*;

  fade_state_t state, state_next;

  logic [7:0]       from_level;
  logic [7:0]       to_level;
  logic [15:0]      dur;
  logic             take_goal;
  logic [7:0]       mcand;
  logic [23:0]      addend;
  logic [23:0]      acc;
  logic [15:0]      rem;
  logic [CNT_W-1:0] cnt;

  logic        shortcut;
  logic [7:0]  span;
  logic [16:0] rem_sh;
  logic        fits;
  logic [16:0] rem_diff;
  logic [24:0] up_sum;
  logic [7:0]  up_level;
  logic [7:0]  down_level;

  // Goal is taken directly once the fade is over or there is nothing to fade.
  assign shortcut = (req.elapsed >= {16'd0, duration}) || (req.from_level == req.to_level);
  assign span = (req.from_level > req.to_level) ? (req.from_level - req.to_level)
                                                : (req.to_level - req.from_level);

  // One restoring divide step; the remainder always stays below the duration.
  assign rem_sh   = {rem, acc[23]};
  assign fits     = rem_sh >= {1'b0, dur};
  assign rem_diff = rem_sh - {1'b0, dur};

  // Apply the quotient as a step up or down with saturation.
  assign up_sum     = {17'd0, from_level} + {1'b0, acc};
  assign up_level   = (up_sum > 25'd255) ? 8'd255 : up_sum[7:0];
  assign down_level = (acc > {16'd0, from_level}) ? 8'd0 : (from_level - acc[7:0]);

  assign rsp.done  = (state == FU_FIN);
  assign rsp.level = take_goal ? to_level :
                     (from_level < to_level) ? up_level : down_level;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      FU_IDLE: begin
        if (req.go) begin
          state_next = shortcut ? FU_FIN : FU_MUL;
        end
      end
      FU_MUL: begin
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          state_next = FU_DIV;
        end
      end
      FU_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = FU_FIN;
        end
      end
      FU_FIN: begin
        state_next = FU_IDLE;
      end
      default: begin
        state_next = FU_IDLE;
      end
    endcase
  end

  // Datapath: the accumulator starts at half the duration for rounding, collects
  // the product one multiplier bit a cycle, then turns into the quotient.
  always_ff @(posedge clk) begin
    case (state)
      FU_IDLE: begin
        if (req.go) begin
          from_level <= req.from_level;
          to_level   <= req.to_level;
          dur        <= duration;
          take_goal  <= shortcut;
          mcand      <= span;
          addend     <= {8'd0, req.elapsed[15:0]};
          acc        <= {9'd0, duration[15:1]};
          rem        <= '0;
          cnt        <= '0;
        end
      end
      FU_MUL: begin
        if (mcand[0]) begin
          acc <= acc + addend;
        end
        addend <= {addend[22:0], 1'b0};
        mcand  <= {1'b0, mcand[7:1]};
        cnt    <= (cnt == CNT_W'(MUL_STEPS - 1)) ? '0 : cnt + 1'b1;
      end
      FU_DIV: begin
        rem <= fits ? rem_diff[15:0] : rem_sh[15:0];
        acc <= {acc[22:0], fits};
        cnt <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/timed_alpha_fade_with_lease_top.sv -----
// Top level of the timed alpha fade with lease block.
//
//  channel  modport  beat carries
//  ev       sink     kind, target_level, time_stamp
//  res      source   level, changed, interactive
//  cfg      sink     index, data (register write)
//
// One event is in work at a time. An accepted event is evaluated in ST_EVAL;
// set target, authorize, revoke and an advance before the first start then go
// straight to ST_EMIT, while an advance after the start waits in ST_FADE for the
// fade unit's 8-step serial multiply and 24-step restoring divide (an advance
// that lands on the goal directly skips both). Reset clears the sequencer and
// block state and loads the register reset values. A result beat waits in the
// output register while the next event is accepted and worked on; it is held only at the final step.
module timed_alpha_fade_with_lease_top (
  input logic         clk,
  input logic         rst,
  tafl_event_if.sink  ev,
  tafl_result_if.source res,
  tafl_cfg_if.sink    cfg
);
  import tafl_pkg::*;

  top_state_t state, state_next;

  // Configuration registers.
  logic [15:0] fade_duration;
  logic [31:0] stale_bound;
  logic [7:0]  interaction_cutoff;

  // Block state.
  logic        started;
  logic        leased;
  logic [7:0]  current_level;
  logic [7:0]  start_level;
  logic [7:0]  goal_level;
  logic [31:0] fade_start_time;
  logic [31:0] lease_time;

  logic        started_next;
  logic        leased_next;
  logic [7:0]  current_level_next;
  logic [7:0]  start_level_next;
  logic [7:0]  goal_level_next;
  logic [31:0] fade_start_time_next;
  logic [31:0] lease_time_next;

  // Held event.
  kind_t       ev_kind;
  logic [7:0]  ev_target;
  logic [31:0] ev_time;

  logic        changed;
  logic        stale;
  logic        need_fade;

  // Output register.
  logic        out_valid;
  logic [7:0]  out_level;
  logic        out_changed;
  logic        out_interactive;
  logic        load_out;

  fade_req_t   fade_req;
  fade_rsp_t   fade_rsp;

  tafl_fade_unit u_fade (
    .clk      (clk),
    .rst      (rst),
    .duration (fade_duration),
    .req      (fade_req),
    .rsp      (fade_rsp)
  );

  assign cfg.ready = 1'b1;
  assign ev.ready  = (state == ST_IDLE);

  assign res.valid       = out_valid;
  assign res.level       = out_level;
  assign res.changed     = out_changed;
  assign res.interactive = out_interactive;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_duration      <= FADE_DURATION_RESET;
      stale_bound        <= STALE_BOUND_RESET;
      interaction_cutoff <= INTERACTION_CUTOFF_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_FADE_DURATION:      fade_duration      <= cfg.data[15:0];
        CFG_STALE_BOUND:        stale_bound        <= cfg.data;
        CFG_INTERACTION_CUTOFF: interaction_cutoff <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Lease has gone stale by the wrapped time since the last authorization.
  assign stale = leased && ((ev_time - lease_time) >= stale_bound);

  // Event semantics: the state after the held event, before any fade step.
  always_comb begin
    started_next         = started;
    leased_next          = leased;
    current_level_next   = current_level;
    start_level_next     = start_level;
    goal_level_next      = goal_level;
    fade_start_time_next = fade_start_time;
    lease_time_next      = lease_time;
    case (ev_kind)
      KIND_SET_TARGET: begin
        if (!started) begin
          started_next         = 1'b1;
          leased_next          = 1'b0;
          current_level_next   = 8'd0;
          goal_level_next      = 8'd0;
          lease_time_next      = 32'd0;
          fade_start_time_next = ev_time;
          start_level_next     = 8'd0;
        end
        if (goal_level_next != ev_target) begin
          start_level_next     = current_level_next;
          goal_level_next      = ev_target;
          fade_start_time_next = ev_time;
        end
      end
      KIND_AUTHORIZE: begin
        if (!started) begin
          started_next         = 1'b1;
          current_level_next   = 8'd0;
          start_level_next     = 8'd0;
          goal_level_next      = 8'd0;
          fade_start_time_next = 32'd0;
        end
        leased_next     = 1'b1;
        lease_time_next = ev_time;
        if (goal_level_next != ev_target) begin
          start_level_next     = current_level_next;
          goal_level_next      = ev_target;
          fade_start_time_next = ev_time;
        end
      end
      KIND_REVOKE: begin
        if (started) begin
          leased_next = 1'b0;
          if (goal_level != 8'd0) begin
            start_level_next     = current_level;
            goal_level_next      = 8'd0;
            fade_start_time_next = ev_time;
          end
        end
      end
      KIND_ADVANCE: begin
        if (started && stale) begin
          leased_next = 1'b0;
          if (goal_level != 8'd0) begin
            start_level_next     = current_level;
            goal_level_next      = 8'd0;
            fade_start_time_next = ev_time;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign need_fade = (ev_kind == KIND_ADVANCE) && started;

  // Fade request is issued in the evaluation cycle from the updated state.
  assign fade_req.go         = (state == ST_EVAL) && need_fade;
  assign fade_req.from_level = start_level_next;
  assign fade_req.to_level   = goal_level_next;
  assign fade_req.elapsed    = ev_time - fade_start_time_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and output load.
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (ev.valid) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = need_fade ? ST_FADE : ST_EMIT;
      end
      ST_FADE: begin
        if (fade_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || res.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Capture the accepted event beat.
  always_ff @(posedge clk) begin
    if (ev.valid && ev.ready) begin
      ev_kind   <= ev.kind;
      ev_target <= ev.target_level;
      ev_time   <= ev.time_stamp;
    end
  end

  // Block state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      leased          <= 1'b0;
      current_level   <= 8'd0;
      start_level     <= 8'd0;
      goal_level      <= 8'd0;
      fade_start_time <= 32'd0;
      lease_time      <= 32'd0;
      changed         <= 1'b0;
    end else if (state == ST_EVAL) begin
      started         <= started_next;
      leased          <= leased_next;
      current_level   <= current_level_next;
      start_level     <= start_level_next;
      goal_level      <= goal_level_next;
      fade_start_time <= fade_start_time_next;
      lease_time      <= lease_time_next;
      changed         <= 1'b0;
    end else if ((state == ST_FADE) && fade_rsp.done) begin
      current_level <= fade_rsp.level;
      changed       <= (fade_rsp.level != current_level);
    end
  end

  // Output register: a waiting result beat does not block the next event.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_level       <= current_level;
      out_changed     <= changed;
      out_interactive <= leased && (current_level >= interaction_cutoff);
    end
  end

  // An accepted event is evaluated in the next cycle.
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    ev.valid && ev.ready |=> state == ST_EVAL)
    else $error("accepted event not evaluated");

  // The fade unit is started only from the evaluation cycle of an advance.
  a_go_eval: assert property (@(posedge clk) disable iff (rst)
    fade_req.go |-> (state == ST_EVAL) && (ev_kind == KIND_ADVANCE))
    else $error("fade unit started outside an advance");

  // The fade unit answers only while the sequencer waits for it.
  a_done_fade: assert property (@(posedge clk) disable iff (rst)
    fade_rsp.done |-> state == ST_FADE)
    else $error("fade answer while not waiting");

  // Before the first start the block holds no lease and a zero level.
  a_not_started: assert property (@(posedge clk) disable iff (rst)
    !started |-> (current_level == 8'd0) && !leased)
    else $error("state changed before start");

  // A changed flag only comes from an advance.
  a_changed_advance: assert property (@(posedge clk) disable iff (rst)
    load_out && changed |-> ev_kind == KIND_ADVANCE)
    else $error("changed flag outside an advance");

endmodule
